@@ rtl/psca_pkg.sv @@
`timescale 1ns / 1ps
// Shared constants, types and the size-class function of the power-of-two allocator.
// No dependencies.
package psca_pkg;

    localparam int HEAP_PAGES     = 64;
    localparam int PAGE_BYTES     = 4096;
    localparam int SIZE_CLASSES   = 9;
    localparam int SMALLEST_BLOCK = 16;
    localparam int HEADER_BYTES   = 4;

    localparam int UNITS       = (HEAP_PAGES * PAGE_BYTES) / SMALLEST_BLOCK;
    localparam int PAGE_UNITS  = PAGE_BYTES / SMALLEST_BLOCK;
    localparam int BLK_W       = $clog2(UNITS);
    localparam int CLS_W       = $clog2(SIZE_CLASSES);
    localparam int PAGE_W      = $clog2(HEAP_PAGES + 1);
    localparam int LEFT_W      = $clog2(PAGE_UNITS);
    localparam int UNIT_SHIFT  = $clog2(SMALLEST_BLOCK);
    localparam int PAGE_SHIFT  = $clog2(PAGE_UNITS);
    localparam int BYTES_SHIFT = $clog2(PAGE_BYTES);
    localparam int LARGEST_RAW = SMALLEST_BLOCK << (SIZE_CLASSES - 1);
    localparam int LARGEST     = (LARGEST_RAW > PAGE_BYTES) ? PAGE_BYTES : LARGEST_RAW;

    localparam int SIZE_W  = 12;
    localparam int NEED_W  = 13;
    localparam int ADDR_W  = 18;
    localparam int TOTAL_W = 19;
    localparam int ST_W    = 2;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_PAGE = 2'd1;
    localparam logic [ST_W-1:0] ST_TOO_BIG = 2'd2;

    typedef struct packed {
        logic              op;
        logic              too_large;
        logic [CLS_W-1:0]  cls;
        logic [SIZE_W-1:0] size;
        logic [BLK_W-1:0]  blk;
    } t_entry;

    typedef struct packed {
        logic [ST_W-1:0]    status;
        logic [ADDR_W-1:0]  address;
        logic [TOTAL_W-1:0] bytes_allocated;
        logic [TOTAL_W-1:0] bytes_reserved;
    } t_rsp;

    // smallest class whose block holds need bytes; saturate at the last class
    function automatic logic [CLS_W-1:0] class_of(input logic [NEED_W-1:0] need);
        logic [CLS_W-1:0] k;
        k = CLS_W'(SIZE_CLASSES - 1);
        for (int i = SIZE_CLASSES - 2; i >= 0; i--) begin
            if (32'(need) <= (SMALLEST_BLOCK << i)) begin
                k = CLS_W'(i);
            end
        end
        return k;
    endfunction

endpackage

@@ rtl/psca_if.sv @@
`timescale 1ns / 1ps
// Request and response channel interfaces of the allocator.
// Depends on psca_pkg for field widths.
interface psca_req_if;
    logic                        valid;
    logic                        ready;
    logic                        operation;
    logic [psca_pkg::SIZE_W-1:0] request_size;
    logic [psca_pkg::ADDR_W-1:0] block_address;

    modport source (output valid, output operation, output request_size,
                    output block_address, input ready);
    modport sink   (input valid, input operation, input request_size,
                    input block_address, output ready);
endinterface

interface psca_rsp_if;
    logic                         valid;
    logic                         ready;
    logic [psca_pkg::ST_W-1:0]    status;
    logic [psca_pkg::ADDR_W-1:0]  address;
    logic [psca_pkg::TOTAL_W-1:0] bytes_allocated;
    logic [psca_pkg::TOTAL_W-1:0] bytes_reserved;

    modport source (output valid, output status, output address,
                    output bytes_allocated, output bytes_reserved, input ready);
    modport sink   (input valid, input status, input address,
                    input bytes_allocated, input bytes_reserved, output ready);
endinterface

@@ rtl/pow2_size_class_allocator.sv @@
`timescale 1ns / 1ps
// Top level of the power-of-two size-class allocator: front end, queue, back end.
// Depends on psca_pkg, psca_if, psca_front and psca_back.

// The back end takes a request in its idle state, reading the class's next link
// and the freed block's stored size from the synchronous link and size memories,
// and commits it in its exec state, updating the stack heads, carve state and
// totals and loading the response register. A two-entry queue in the front end
// keeps accepting requests while the back end works or the response waits; the
// back end takes a new one only after commit. No clearing pass follows reset.
module pow2_size_class_allocator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    psca_req_if.sink    i_req,
    psca_rsp_if.source  o_rsp
);
    import psca_pkg::*;

    t_entry w_entry;
    logic   w_entry_valid;
    logic   w_entry_ready;

    psca_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (i_req),
        .o_entry       (w_entry),
        .o_entry_valid (w_entry_valid),
        .i_entry_ready (w_entry_ready)
    );

    psca_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_entry       (w_entry),
        .i_entry_valid (w_entry_valid),
        .o_entry_ready (w_entry_ready),
        .o_rsp         (o_rsp)
    );

    a_free_not_rejected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_entry_valid && w_entry.op == OP_FREE) |-> !w_entry.too_large)
        else $error("free request flagged as oversized");

    a_error_no_address: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status != ST_OK) |-> (o_rsp.address == '0))
        else $error("error response carries an address");

    a_status_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.status == ST_OK || o_rsp.status == ST_NO_PAGE ||
                         o_rsp.status == ST_TOO_BIG))
        else $error("illegal response status");

    a_back_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_entry_valid && w_entry_ready) |=> !w_entry_ready)
        else $error("back end took two requests in a row");

endmodule

@@ rtl/psca_front.sv @@
`timescale 1ns / 1ps
// Front end: accept requests, classify them and queue them for the back end.
// Depends on psca_pkg and psca_req_if.
module psca_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    psca_req_if.sink          i_req,
    output psca_pkg::t_entry  o_entry,
    output logic              o_entry_valid,
    input  logic              i_entry_ready
);
    import psca_pkg::*;

    t_entry            w_dec;
    logic [NEED_W-1:0] w_need;
    logic [ADDR_W-1:0] w_base;
    logic              w_push;
    logic              w_pop;

    t_entry            r_q [2];
    logic              r_wr_ptr;
    logic              r_rd_ptr;
    logic [1:0]        r_count;

    always_comb begin
        w_need          = NEED_W'(i_req.request_size) + NEED_W'(HEADER_BYTES);
        w_base          = i_req.block_address - ADDR_W'(HEADER_BYTES);
        w_dec.op        = i_req.operation;
        w_dec.too_large = (i_req.operation == OP_ALLOC) && (32'(w_need) > LARGEST);
        w_dec.cls       = class_of(w_need);
        w_dec.size      = i_req.request_size;
        w_dec.blk       = w_base[UNIT_SHIFT +: BLK_W];
    end

    assign i_req.ready   = (r_count != 2'd2);
    assign w_push        = i_req.valid && i_req.ready;
    assign o_entry_valid = (r_count != 2'd0);
    assign w_pop         = o_entry_valid && i_entry_ready;
    assign o_entry       = r_q[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr_ptr] <= w_dec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (w_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 2'd1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

endmodule

@@ rtl/psca_back.sv @@
`timescale 1ns / 1ps
// Back end: class stacks, page carving, link and size memories, result register.
// Depends on psca_pkg and psca_rsp_if.
module psca_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  psca_pkg::t_entry  i_entry,
    input  logic              i_entry_valid,
    output logic              o_entry_ready,
    psca_rsp_if.source        o_rsp
);
    import psca_pkg::*;

    localparam logic S_IDLE = 1'b0;
    localparam logic S_EXEC = 1'b1;

    logic               r_state;
    t_entry             r_cur;
    logic [BLK_W:0]     r_free_head  [SIZE_CLASSES];
    logic [BLK_W-1:0]   r_carve_ptr  [SIZE_CLASSES];
    logic [LEFT_W-1:0]  r_carve_left [SIZE_CLASSES];
    logic [PAGE_W-1:0]  r_pages;
    logic [TOTAL_W-1:0] r_bytes;
    logic [BLK_W:0]     r_next_link  [UNITS];
    logic [SIZE_W-1:0]  r_block_size [UNITS];
    logic [BLK_W:0]     r_link_q;
    logic [SIZE_W-1:0]  r_size_q;
    logic               r_out_valid;
    t_rsp               r_out;

    logic [BLK_W:0]     n_free_head  [SIZE_CLASSES];
    logic [BLK_W-1:0]   n_carve_ptr  [SIZE_CLASSES];
    logic [LEFT_W-1:0]  n_carve_left [SIZE_CLASSES];
    logic [PAGE_W-1:0]  n_pages;
    logic [TOTAL_W-1:0] n_bytes;

    logic               w_take;
    logic               w_commit;
    logic               w_got;
    logic [BLK_W-1:0]   w_blk;
    logic [BLK_W-1:0]   w_step;
    logic [CLS_W-1:0]   w_free_cls;
    logic [ST_W-1:0]    w_status;
    logic [ADDR_W-1:0]  w_addr;
    logic               w_link_we;
    logic               w_size_we;

    assign o_entry_ready = (r_state == S_IDLE);
    assign w_take        = o_entry_ready && i_entry_valid;
    assign w_commit      = (r_state == S_EXEC) && (!r_out_valid || o_rsp.ready);

    always_comb begin
        n_free_head  = r_free_head;
        n_carve_ptr  = r_carve_ptr;
        n_carve_left = r_carve_left;
        n_pages      = r_pages;
        n_bytes      = r_bytes;
        w_got        = 1'b0;
        w_blk        = '0;
        w_status     = ST_OK;
        w_addr       = '0;
        w_link_we    = 1'b0;
        w_size_we    = 1'b0;
        w_step       = BLK_W'(1) << r_cur.cls;
        w_free_cls   = class_of(NEED_W'(r_size_q) + NEED_W'(HEADER_BYTES));
        if (r_cur.op == OP_ALLOC) begin
            if (r_cur.too_large) begin
                w_status = ST_TOO_BIG;
            end else if (r_free_head[r_cur.cls][BLK_W]) begin
                w_got                   = 1'b1;
                w_blk                   = r_free_head[r_cur.cls][BLK_W-1:0];
                n_free_head[r_cur.cls]  = r_link_q;
            end else if (r_carve_left[r_cur.cls] != '0) begin
                w_got                   = 1'b1;
                w_blk                   = r_carve_ptr[r_cur.cls];
                n_carve_ptr[r_cur.cls]  = w_blk + w_step;
                n_carve_left[r_cur.cls] = r_carve_left[r_cur.cls] - LEFT_W'(1);
            end else if (32'(r_pages) < HEAP_PAGES) begin
                w_got                   = 1'b1;
                w_blk                   = BLK_W'(r_pages) << PAGE_SHIFT;
                n_carve_ptr[r_cur.cls]  = w_blk + w_step;
                n_carve_left[r_cur.cls] =
                    LEFT_W'(((LEFT_W + 1)'(PAGE_UNITS) >> r_cur.cls) - (LEFT_W + 1)'(1));
                n_pages                 = r_pages + PAGE_W'(1);
            end else begin
                w_status = ST_NO_PAGE;
            end
            if (w_got) begin
                w_size_we = w_commit;
                n_bytes   = r_bytes + TOTAL_W'(r_cur.size);
                w_addr    = ADDR_W'({w_blk, UNIT_SHIFT'(HEADER_BYTES)});
            end
        end else begin
            w_link_we               = w_commit;
            n_free_head[w_free_cls] = {1'b1, r_cur.blk};
            n_bytes = (r_bytes >= TOTAL_W'(r_size_q)) ? r_bytes - TOTAL_W'(r_size_q) : '0;
        end
    end

    // link and size memories: one read on take, one write on commit
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_link_q <= r_next_link[r_free_head[i_entry.cls][BLK_W-1:0]];
            r_size_q <= r_block_size[i_entry.blk];
        end
        if (w_link_we) begin
            r_next_link[r_cur.blk] <= r_free_head[w_free_cls];
        end
        if (w_size_we) begin
            r_block_size[w_blk] <= r_cur.size;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_cur <= i_entry;
        end
        if (w_commit) begin
            r_out.status          <= w_status;
            r_out.address         <= w_addr;
            r_out.bytes_allocated <= n_bytes;
            r_out.bytes_reserved  <= TOTAL_W'(n_pages) << BYTES_SHIFT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_pages     <= '0;
            r_bytes     <= '0;
            for (int i = 0; i < SIZE_CLASSES; i++) begin
                r_free_head[i]  <= '0;
                r_carve_ptr[i]  <= '0;
                r_carve_left[i] <= '0;
            end
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (w_take) begin
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    if (w_commit) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
            if (w_commit) begin
                r_out_valid  <= 1'b1;
                r_free_head  <= n_free_head;
                r_carve_ptr  <= n_carve_ptr;
                r_carve_left <= n_carve_left;
                r_pages      <= n_pages;
                r_bytes      <= n_bytes;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_rsp.valid           = r_out_valid;
    assign o_rsp.status          = r_out.status;
    assign o_rsp.address         = r_out.address;
    assign o_rsp.bytes_allocated = r_out.bytes_allocated;
    assign o_rsp.bytes_reserved  = r_out.bytes_reserved;

endmodule

@@ bench/testbench.sv @@
`timescale 1ns / 1ps
// Self-checking bench for pow2_size_class_allocator: allocate/free traffic with random idling.
// Depends on psca_pkg and psca_if from the RTL; predicts every response in-line.
module testbench;
    import psca_pkg::*;

    typedef struct packed {
        logic              op;
        logic [SIZE_W-1:0] size;
        logic [ADDR_W-1:0] address;
    } t_req;

    logic i_clk;
    logic i_rst_n;

    psca_req_if req_ch ();
    psca_rsp_if rsp_ch ();

    pow2_size_class_allocator i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    // heap state as the allocator holds it
    bit              head_valid [SIZE_CLASSES];
    int              head_blk   [SIZE_CLASSES];
    int              carve_ptr  [SIZE_CLASSES];
    int              carve_left [SIZE_CLASSES];
    bit              link_valid [UNITS];
    int              link_blk   [UNITS];
    bit [SIZE_W-1:0] size_of    [UNITS];
    int              pages_taken;
    int              bytes_live;

    // blocks handed out, for building frees
    int live_blk [$];
    int ever_blk [$];
    bit in_ever  [UNITS];

    t_req req_pending_q     [$];
    t_rsp rsp_for_pending_q [$];
    t_rsp rsp_due_q         [$];

    t_req drive_rq;
    int   send_gap;
    int   send_burst;
    int   recv_stall;
    int   recv_burst;
    int   fail_count;

    always #5 i_clk = ~i_clk;

    function automatic int fit_class(int need);
        int k;
        k = 0;
        while (k < SIZE_CLASSES - 1 && need > (SMALLEST_BLOCK << k)) k++;
        return k;
    endfunction

    function automatic t_rsp heap_predict(t_req rq);
        t_rsp              rsp;
        int                need;
        int                k;
        int                step;
        int                blk;
        int                stored;
        bit                got;
        logic [ADDR_W-1:0] base;
        rsp = '0;
        if (rq.op == OP_ALLOC) begin
            need = int'(rq.size) + HEADER_BYTES;
            if (need > LARGEST) begin
                rsp.status = ST_TOO_BIG;
            end else begin
                k    = fit_class(need);
                step = (SMALLEST_BLOCK << k) / SMALLEST_BLOCK;
                got  = 1'b1;
                blk  = 0;
                if (head_valid[k]) begin
                    blk           = head_blk[k];
                    head_valid[k] = link_valid[blk];
                    head_blk[k]   = link_blk[blk];
                end else if (carve_left[k] > 0) begin
                    blk           = carve_ptr[k];
                    carve_ptr[k]  = blk + step;
                    carve_left[k] = carve_left[k] - 1;
                end else if (pages_taken < HEAP_PAGES) begin
                    blk           = pages_taken * PAGE_UNITS;
                    carve_ptr[k]  = blk + step;
                    carve_left[k] = PAGE_BYTES / (SMALLEST_BLOCK << k) - 1;
                    pages_taken++;
                end else begin
                    got        = 1'b0;
                    rsp.status = ST_NO_PAGE;
                end
                if (got) begin
                    size_of[blk] = rq.size;
                    bytes_live   = bytes_live + int'(rq.size);
                    rsp.address  = ADDR_W'(blk * SMALLEST_BLOCK + HEADER_BYTES);
                end
            end
        end else begin
            base = rq.address - ADDR_W'(HEADER_BYTES);
            blk  = int'(base >> UNIT_SHIFT);
            if (blk < UNITS) begin
                stored          = int'(size_of[blk]);
                k               = fit_class(stored + HEADER_BYTES);
                link_valid[blk] = head_valid[k];
                link_blk[blk]   = head_blk[k];
                head_valid[k]   = 1'b1;
                head_blk[k]     = blk;
                bytes_live      = (bytes_live >= stored) ? bytes_live - stored : 0;
            end
        end
        rsp.bytes_allocated = TOTAL_W'(bytes_live);
        rsp.bytes_reserved  = TOTAL_W'(pages_taken * PAGE_BYTES);
        return rsp;
    endfunction

    task automatic queue_request(input logic op, input int size, input int addr);
        t_req rq;
        t_rsp rsp;
        int   blk;
        rq.op      = op;
        rq.size    = SIZE_W'(size);
        rq.address = ADDR_W'(addr);
        rsp        = heap_predict(rq);
        if (op == OP_ALLOC && rsp.status == ST_OK) begin
            blk = int'((rsp.address - ADDR_W'(HEADER_BYTES)) >> UNIT_SHIFT);
            live_blk.push_back(blk);
            if (!in_ever[blk]) begin
                in_ever[blk] = 1'b1;
                ever_blk.push_back(blk);
            end
        end
        req_pending_q.push_back(rq);
        rsp_for_pending_q.push_back(rsp);
    endtask

    task automatic queue_alloc(input int size);
        queue_request(OP_ALLOC, size, $urandom_range(0, (1 << ADDR_W) - 1));
    endtask

    task automatic free_block(input int blk, input int offset);
        for (int i = 0; i < live_blk.size(); i++) begin
            if (live_blk[i] == blk) begin
                live_blk.delete(i);
                break;
            end
        end
        queue_request(OP_FREE, $urandom_range(0, (1 << SIZE_W) - 1),
                      blk * SMALLEST_BLOCK + HEADER_BYTES + offset);
    endtask

    task automatic random_request();
        int r;
        int s;
        int off;
        r   = $urandom_range(0, 99);
        s   = $urandom_range(0, 99);
        off = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SMALLEST_BLOCK - 1) : 0;
        if (ever_blk.size() == 0 || r < 55) begin
            if (s < 40)      queue_alloc($urandom_range(0, 60));
            else if (s < 60) queue_alloc($urandom_range(61, 1020));
            else if (s < 80) queue_alloc($urandom_range(LARGEST / 2 - 3, LARGEST - 4));
            else if (s < 95) queue_alloc($urandom_range(0, (1 << SIZE_W) - 1));
            else             queue_alloc($urandom_range(LARGEST - 3, (1 << SIZE_W) - 1));
        end else if (live_blk.size() > 0 && r < 97) begin
            free_block(live_blk[$urandom_range(0, live_blk.size() - 1)], off);
        end else begin
            free_block(ever_blk[$urandom_range(0, ever_blk.size() - 1)], off);
        end
    endtask

    function automatic int idle_len(inout int burst);
        int r;
        if (burst > 0) begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 4) begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(12, 40);
    endfunction

    task automatic report_mismatch(input string msg);
        fail_count++;
        if (fail_count <= 60) $display("mismatch @%0t: %s", $realtime, msg);
    endtask

    task automatic check_response();
        t_rsp got;
        t_rsp want;
        got.status          = rsp_ch.status;
        got.address         = rsp_ch.address;
        got.bytes_allocated = rsp_ch.bytes_allocated;
        got.bytes_reserved  = rsp_ch.bytes_reserved;
        if (rsp_due_q.size() == 0) begin
            report_mismatch($sformatf("unexpected response st=%0d addr=%h alloc=%0d rsv=%0d",
                                      got.status, got.address, got.bytes_allocated,
                                      got.bytes_reserved));
        end else begin
            want = rsp_due_q.pop_front();
            if (got.status !== want.status || got.address !== want.address ||
                got.bytes_allocated !== want.bytes_allocated ||
                got.bytes_reserved !== want.bytes_reserved) begin
                report_mismatch($sformatf(
                    "st %0d/%0d addr %h/%h alloc %0d/%0d rsv %0d/%0d (got/exp)",
                    got.status, want.status, got.address, want.address,
                    got.bytes_allocated, want.bytes_allocated,
                    got.bytes_reserved, want.bytes_reserved));
            end
        end
    endtask

    task automatic wait_drained();
        while (req_pending_q.size() != 0 || rsp_for_pending_q.size() != 0 ||
               rsp_due_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            send_gap     <= 0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                rsp_due_q.push_back(rsp_for_pending_q.pop_front());
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (send_gap > 0) begin
                    send_gap     <= send_gap - 1;
                    req_ch.valid <= 1'b0;
                end else if (req_pending_q.size() > 0) begin
                    drive_rq             = req_pending_q.pop_front();
                    req_ch.valid         <= 1'b1;
                    req_ch.operation     <= drive_rq.op;
                    req_ch.request_size  <= drive_rq.size;
                    req_ch.block_address <= drive_rq.address;
                    send_gap             <= idle_len(send_burst);
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            recv_stall   <= 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) check_response();
            if (recv_stall > 0) begin
                rsp_ch.ready <= 1'b0;
                recv_stall   <= recv_stall - 1;
            end else begin
                rsp_ch.ready <= 1'b1;
                recv_stall   <= idle_len(recv_burst);
            end
        end
    end

    initial begin
        #4_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        int keep_blk;
        i_clk                = 1'b0;
        i_rst_n              = 1'b0;
        req_ch.valid         = 1'b0;
        req_ch.operation     = OP_ALLOC;
        req_ch.request_size  = '0;
        req_ch.block_address = '0;
        rsp_ch.ready         = 1'b0;
        fail_count           = 0;
        send_burst           = 0;
        recv_burst           = 0;

        // class edges, largest request, oversize requests
        queue_alloc(0);
        queue_alloc(SMALLEST_BLOCK - HEADER_BYTES);
        queue_alloc(SMALLEST_BLOCK - HEADER_BYTES + 1);
        queue_alloc(LARGEST - HEADER_BYTES);
        queue_alloc(LARGEST - HEADER_BYTES + 1);
        queue_alloc((1 << SIZE_W) - 1);
        queue_alloc(LARGEST / 2 - HEADER_BYTES);
        queue_alloc(LARGEST / 2 - HEADER_BYTES + 1);
        queue_alloc(124);
        // free all, first one at the far end of its block
        free_block(live_blk[0], SMALLEST_BLOCK - 1);
        while (live_blk.size() > 0) free_block(live_blk[0], 0);
        // reuse from the stack, then free twice so the total would fall below zero and saturates at zero
        queue_alloc(1);
        keep_blk = live_blk[0];
        free_block(keep_blk, 0);
        free_block(keep_blk, 0);

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait_drained();

        for (int i = 0; i < 300; i++) random_request();
        wait_drained();
        for (int i = 0; i < 300; i++) random_request();
        wait_drained();
        repeat (30) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/psca_pkg.sv
rtl/psca_if.sv
rtl/psca_front.sv
rtl/psca_back.sv
rtl/pow2_size_class_allocator.sv
bench/testbench.sv
